[rtl/gpfe_pkg.sv]
// Shared types and constants for the GLL position field extractor.
// Used by the front, queue and back modules; depends on nothing else.
`timescale 1ns / 1ps

package gpfe_pkg;

  localparam logic [7:0] DOLLAR_CHAR = 8'h24;
  localparam logic [7:0] COMMA_CHAR  = 8'h2C;

  localparam logic [23:0] TAG_RESET          = 24'h474C4C;
  localparam logic [3:0]  FIRST_COMMA_RESET  = 4'd1;
  localparam logic [3:0]  SECOND_COMMA_RESET = 4'd3;
  localparam logic [3:0]  COMMA_SAT          = 4'd15;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_SENTENCE_TAG  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_COMMA   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_COMMA  = 2'd2;

  typedef struct packed {
    logic                  valid;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic       field_select;
    logic [7:0] char_value;
    logic [3:0] char_index;
    logic       field_end;
    logic       overflow;
  } res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[rtl/gpfe_front.sv]
// Front end: holds the configuration registers and the per-sentence parser state,
// classifies each accepted byte and pushes any result into the queue. Uses gpfe_pkg.
`timescale 1ns / 1ps

module gpfe_front import gpfe_pkg::*; #(
  parameter int MAX_FIELD_CHARS = 10
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_wr_t    cfg_wr,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  output logic       push,
  output res_t       push_data
);

  localparam logic [3:0] CHAR_MAX = 4'(MAX_FIELD_CHARS);

  logic [23:0] tag_r;
  logic [3:0]  first_comma_r;
  logic [3:0]  second_comma_r;

  logic        in_sentence_r, in_sentence_nxt;
  logic [15:0] prev_chars_r, prev_chars_nxt;
  logic        tag_seen_r, tag_seen_nxt;
  logic [3:0]  comma_count_r, comma_count_nxt;
  logic [3:0]  char_count_r, char_count_nxt;
  logic        overflow_r, overflow_nxt;

  logic is_dollar;
  logic is_comma;
  logic hit_first;
  logic capturing;

  assign is_dollar = (rx_byte == DOLLAR_CHAR);
  assign is_comma  = (rx_byte == COMMA_CHAR);
  assign hit_first = (comma_count_r == first_comma_r);
  assign capturing = hit_first || (comma_count_r == second_comma_r);

  always_comb begin
    in_sentence_nxt = in_sentence_r;
    prev_chars_nxt  = prev_chars_r;
    tag_seen_nxt    = tag_seen_r;
    comma_count_nxt = comma_count_r;
    char_count_nxt  = char_count_r;
    overflow_nxt    = overflow_r;
    push            = 1'b0;
    push_data.field_select = ~hit_first;
    push_data.char_value   = rx_byte;
    push_data.char_index   = char_count_r;
    push_data.field_end    = 1'b0;
    push_data.overflow     = 1'b0;

    if (accept) begin
      if (is_dollar) begin
        in_sentence_nxt = 1'b1;
        prev_chars_nxt  = '0;
        tag_seen_nxt    = 1'b0;
        comma_count_nxt = '0;
        char_count_nxt  = '0;
        overflow_nxt    = 1'b0;
      end else if (in_sentence_r && !tag_seen_r) begin
        if ({prev_chars_r, rx_byte} == tag_r) begin
          tag_seen_nxt = 1'b1;
        end
        prev_chars_nxt = {prev_chars_r[7:0], rx_byte};
      end else if (in_sentence_r && is_comma) begin
        // A comma closes the current field; only captured fields report it.
        push                 = capturing;
        push_data.char_value = '0;
        push_data.field_end  = 1'b1;
        push_data.overflow   = overflow_r;
        if (comma_count_r != COMMA_SAT) begin
          comma_count_nxt = comma_count_r + 4'd1;
        end
        char_count_nxt = '0;
        overflow_nxt   = 1'b0;
      end else if (in_sentence_r && capturing) begin
        if (char_count_r < CHAR_MAX) begin
          push           = 1'b1;
          char_count_nxt = char_count_r + 4'd1;
        end else begin
          overflow_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r          <= TAG_RESET;
      first_comma_r  <= FIRST_COMMA_RESET;
      second_comma_r <= SECOND_COMMA_RESET;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        CFG_SENTENCE_TAG: tag_r          <= cfg_wr.data;
        CFG_FIRST_COMMA:  first_comma_r  <= cfg_wr.data[3:0];
        CFG_SECOND_COMMA: second_comma_r <= cfg_wr.data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_sentence_r <= 1'b0;
      prev_chars_r  <= '0;
      tag_seen_r    <= 1'b0;
      comma_count_r <= '0;
      char_count_r  <= '0;
      overflow_r    <= 1'b0;
    end else begin
      in_sentence_r <= in_sentence_nxt;
      prev_chars_r  <= prev_chars_nxt;
      tag_seen_r    <= tag_seen_nxt;
      comma_count_r <= comma_count_nxt;
      char_count_r  <= char_count_nxt;
      overflow_r    <= overflow_nxt;
    end
  end

endmodule

[rtl/gpfe_queue.sv]
// Two-entry result queue that decouples the parser from the output stage.
// Uses the res_t and q_stat_t types of gpfe_pkg.
`timescale 1ns / 1ps

module gpfe_queue import gpfe_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  res_t    push_data,
  input  logic    pop,
  output res_t    head,
  output q_stat_t stat
);

  res_t       mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign stat.full  = (count_r == 2'd2);
  assign stat.empty = (count_r == 2'd0);
  assign head       = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

[rtl/gpfe_back.sv]
// Back end: pops results from the queue into the output register and holds them
// while the receiver stalls. Uses the res_t and q_stat_t types of gpfe_pkg.
`timescale 1ns / 1ps

module gpfe_back import gpfe_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  res_t    head,
  input  q_stat_t stat,
  output logic    pop,
  input  logic    out_stall,
  output logic    out_valid,
  output res_t    out_data
);

  logic out_valid_r, out_valid_nxt;
  res_t out_data_r;

  // The register can take a new result when it is empty or is being transferred now.
  assign pop = !stat.empty && (!out_valid_r || !out_stall);

  always_comb begin
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_stall) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/gll_position_field_extractor.sv]
// GLL position field extractor: picks latitude and longitude characters out of
// an NMEA byte stream.
//
// Input channel: in_valid / in_stall with in_rx_byte, one received byte per
// transfer. Result channel: out_valid / out_stall with one result per transfer:
// a captured character with its index in the field, or a field end result
// carrying the kept character count and the overflow flag.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; index 0 is
// the 24-bit sentence tag, 1 and 2 the comma counts that open the two fields.
// cfg_ready is always high; write only while the block is idle.
//
// Throughput is one byte per cycle while in_stall is low; the parser state is
// registered at the transfer edge. The parser writes each result into the
// two-entry queue at the transfer edge; the output register takes it while
// empty or while its result is transferred. When the receiver stalls, the output
// register holds its result and the queue absorbs up to two more; in_stall
// rises only when the queue is full.
// Synchronous reset clears the parser state, the queue and out_valid and
// restores the default tag (GLL) and comma counts 1 and 3.
`timescale 1ns / 1ps

module gll_position_field_extractor import gpfe_pkg::*; #(
  parameter int MAX_FIELD_CHARS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_rx_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_field_select,
  output logic [7:0]            out_char_value,
  output logic [3:0]            out_char_index,
  output logic                  out_field_end,
  output logic                  out_overflow,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_wr_t cfg_wr;
  q_stat_t q_stat;
  res_t    push_data;
  res_t    head;
  res_t    out_data;
  logic    push;
  logic    pop;
  logic    accept;

  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;

  gpfe_front #(
    .MAX_FIELD_CHARS(MAX_FIELD_CHARS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr   (cfg_wr),
    .accept   (accept),
    .rx_byte  (in_rx_byte),
    .push     (push),
    .push_data(push_data)
  );

  gpfe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  gpfe_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .stat     (q_stat),
    .pop      (pop),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  assign out_field_select = out_data.field_select;
  assign out_char_value   = out_data.char_value;
  assign out_char_index   = out_data.char_index;
  assign out_field_end    = out_data.field_end;
  assign out_overflow     = out_data.overflow;

endmodule

[rtl/gpfe_checker.sv]
// Port-level checker for the GLL position field extractor, attached by bind.
// Sees only the top-level ports; depends on no package.
`timescale 1ns / 1ps

module gpfe_checker #(
  parameter int MAX_FIELD_CHARS = 10
) (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_field_select,
  input logic [7:0] out_char_value,
  input logic [3:0] out_char_index,
  input logic       out_field_end,
  input logic       out_overflow
);

  localparam logic [3:0] CHAR_MAX = 4'(MAX_FIELD_CHARS);

  // A stalled result must stay up and unchanged.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_field_select) &&
      $stable(out_char_value) && $stable(out_char_index) &&
      $stable(out_field_end) && $stable(out_overflow))
    else $error("stalled result changed");

  // Character results never carry overflow and stay below the field limit.
  a_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_field_end |-> !out_overflow && (out_char_index < CHAR_MAX))
    else $error("bad character result");

  // End results carry a zero character and a count no larger than the limit.
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_field_end |-> (out_char_value == 8'd0) && (out_char_index <= CHAR_MAX))
    else $error("bad field end result");

  // Nothing is offered right after reset.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind gll_position_field_extractor gpfe_checker #(
  .MAX_FIELD_CHARS(MAX_FIELD_CHARS)
) u_gpfe_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_field_select(out_field_select),
  .out_char_value  (out_char_value),
  .out_char_index  (out_char_index),
  .out_field_end   (out_field_end),
  .out_overflow    (out_overflow)
);

[verif/gpfe_field_checker.sv]
// Field checker for the GLL position field extractor: predicts the captured
// characters and field ends from the observed byte and register transfers.
// Depends on gpfe_pkg for the result type, the special characters and indexes.
`timescale 1ns / 1ps

module gpfe_field_checker import gpfe_pkg::*; #(
  parameter int MAX_FIELD_CHARS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [7:0]            in_rx_byte,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  out_field_select,
  input  logic [7:0]            out_char_value,
  input  logic [3:0]            out_char_index,
  input  logic                  out_field_end,
  input  logic                  out_overflow,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    pending,
  output int                    chars_checked,
  output int                    ends_checked
);

  // Register copies.
  logic [23:0] tag_reg;
  logic [3:0]  open_first;
  logic [3:0]  open_second;

  // Parser state.
  logic        in_frame;
  logic [15:0] history;
  logic        armed;
  logic [3:0]  commas;
  logic [3:0]  kept;
  logic        dropped;

  res_t due_results[$];

  task automatic track_byte(input logic [7:0] b);
    logic cap;
    res_t r;
    cap = (commas == open_first) || (commas == open_second);
    r.field_select = (commas != open_first);
    if (b == DOLLAR_CHAR) begin
      in_frame = 1'b1;
      history  = '0;
      armed    = 1'b0;
      commas   = '0;
      kept     = '0;
      dropped  = 1'b0;
    end else if (!in_frame) begin
      // Bytes outside any sentence are ignored.
    end else if (!armed) begin
      if ({history, b} == tag_reg) armed = 1'b1;
      history = {history[7:0], b};
    end else if (b == COMMA_CHAR) begin
      if (cap) begin
        r.char_value = '0;
        r.char_index = kept;
        r.field_end  = 1'b1;
        r.overflow   = dropped;
        due_results.push_back(r);
      end
      if (commas != COMMA_SAT) commas = commas + 4'd1;
      kept    = '0;
      dropped = 1'b0;
    end else if (cap) begin
      if (kept < MAX_FIELD_CHARS) begin
        r.char_value = b;
        r.char_index = kept;
        r.field_end  = 1'b0;
        r.overflow   = 1'b0;
        due_results.push_back(r);
        kept = kept + 4'd1;
      end else begin
        dropped = 1'b1;
      end
    end
  endtask

  always @(posedge clk) begin
    res_t got;
    res_t want;
    got = {out_field_select, out_char_value, out_char_index, out_field_end, out_overflow};
    if (!rst_n) begin
      tag_reg       = TAG_RESET;
      open_first    = FIRST_COMMA_RESET;
      open_second   = SECOND_COMMA_RESET;
      in_frame      = 1'b0;
      history       = '0;
      armed         = 1'b0;
      commas        = '0;
      kept          = '0;
      dropped       = 1'b0;
      mismatches    = 0;
      chars_checked = 0;
      ends_checked  = 0;
      due_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result transfer: expected none, actual %s",
                   $time, $sformatf("sel=%0d char=%02h idx=%0d end=%0d ovf=%0d",
                   got.field_select, got.char_value, got.char_index,
                   got.field_end, got.overflow));
          mismatches++;
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch: expected sel=%0d char=%02h idx=%0d end=%0d ovf=%0d,",
                     $time, want.field_select, want.char_value, want.char_index,
                     want.field_end, want.overflow);
            $display("    actual sel=%0d char=%02h idx=%0d end=%0d ovf=%0d",
                     got.field_select, got.char_value, got.char_index,
                     got.field_end, got.overflow);
            mismatches++;
          end
          if (want.field_end) ends_checked++;
          else chars_checked++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SENTENCE_TAG: tag_reg     = cfg_data[23:0];
          CFG_FIRST_COMMA:  open_first  = cfg_data[3:0];
          CFG_SECOND_COMMA: open_second = cfg_data[3:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) track_byte(in_rx_byte);
    end
    pending = due_results.size();
  end

endmodule

[verif/testbench.sv]
// Top of the GLL position field extractor testbench: clock, reset, byte and
// register stimulus, receiver stalls and the verdict.
// Depends on gpfe_pkg, the extractor RTL and gpfe_field_checker.
`timescale 1ns / 1ps

module testbench;
  import gpfe_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [23:0] TAG_RMC = 24'h524D43;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_rx_byte = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_field_select;
  logic [7:0]            out_char_value;
  logic [3:0]            out_char_index;
  logic                  out_field_end;
  logic                  out_overflow;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // While calm is set neither side inserts idle cycles.
  logic calm = 1'b0;

  int mismatches;
  int pending;
  int chars_checked;
  int ends_checked;

  logic [7:0]  byte_plan[$];
  int          sentence_bytes;
  logic [23:0] cur_tag;

  gll_position_field_extractor dut (.*);

  gpfe_field_checker checker_i (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #200000;
    $display("end of test: mismatches");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= !calm && ($urandom_range(99) < 33);
  end

  task automatic send_byte(input logic [7:0] b);
    while (!calm && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_plan();
    while (byte_plan.size() != 0) send_byte(byte_plan.pop_front());
  endtask

  // Holds the sender off until every expected result has been transferred,
  // then lets the pipeline settle so the block is idle for register writes.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input logic [23:0] tag, input logic [3:0] first,
                           input logic [3:0] second);
    write_reg(CFG_SENTENCE_TAG, tag);
    write_reg(CFG_FIRST_COMMA, {20'd0, first});
    write_reg(CFG_SECOND_COMMA, {20'd0, second});
    cfg_valid <= 1'b0;
    cur_tag = tag;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) byte_plan.push_back(s[i]);
  endtask

  function automatic logic [7:0] field_char();
    logic [7:0] b;
    string digits;
    digits = "0123456789.NSEW";
    if ($urandom_range(99) < 80) begin
      b = digits[$urandom_range(digits.len() - 1)];
    end else begin
      do b = 8'($urandom_range(255)); while (b == DOLLAR_CHAR || b == COMMA_CHAR);
    end
    return b;
  endfunction

  task automatic add_body(input bit brief);
    int len;
    if (brief) len = ($urandom_range(9) == 0) ? 12 : $urandom_range(3);
    else if ($urandom_range(99) < 15) len = $urandom_range(9, 13);
    else len = $urandom_range(6);
    repeat (len) byte_plan.push_back(field_char());
  endtask

  // One sentence: '$', optional talker prefix, tag (leading zero bytes left
  // out), then comma-separated bodies and a checksum trailer.
  task automatic add_sentence(input int min_commas, input bit wrong_tag);
    logic [23:0] tag;
    int commas;
    bit started;
    tag = cur_tag;
    if (wrong_tag) tag[7:0] = tag[7:0] ^ 8'h01;
    byte_plan.push_back(DOLLAR_CHAR);
    if (tag[23:16] != 8'h00 && $urandom_range(1) == 1) add_text("GP");
    started = 1'b0;
    for (int k = 2; k >= 0; k--) begin
      if (started || tag[k*8 +: 8] != 8'h00) begin
        byte_plan.push_back(tag[k*8 +: 8]);
        started = 1'b1;
      end
    end
    add_body(min_commas > 0);
    if (min_commas > 0) commas = $urandom_range(min_commas, min_commas + 3);
    else if ($urandom_range(99) < 15) commas = $urandom_range(14, 18);
    else commas = $urandom_range(2, 8);
    repeat (commas) begin
      byte_plan.push_back(COMMA_CHAR);
      add_body(min_commas > 0);
    end
    add_text("*4A\r\n");
  endtask

  // Mostly well-formed sentences; the rest are wrong tags, cut-off sentences
  // and bursts of arbitrary bytes.
  task automatic run_random(input int goal, input int min_commas);
    int stop;
    int pick;
    int keep;
    stop = sentence_bytes + goal;
    while (sentence_bytes < stop) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        add_sentence(min_commas, 1'b0);
      end else if (pick < 72) begin
        add_sentence(min_commas, 1'b1);
      end else if (pick < 87) begin
        add_sentence(min_commas, 1'b0);
        keep = $urandom_range(2, byte_plan.size() - 1);
        while (byte_plan.size() > keep) void'(byte_plan.pop_back());
      end
      sentence_bytes += byte_plan.size();
      if (pick >= 87) begin
        repeat ($urandom_range(1, 5)) byte_plan.push_back(8'($urandom_range(255)));
      end
      send_plan();
    end
  endtask

  initial begin
    sentence_bytes = 0;
    cur_tag = TAG_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a byte before any sentence, a field with both byte extremes
    // that runs past the limit, an empty field, a '$' in the middle of a
    // field and an empty first field.
    add_text("Z$GLL,");
    byte_plan.push_back(8'h00);
    byte_plan.push_back(8'hFF);
    add_text("123456789,,A$GLL,,");
    sentence_bytes += byte_plan.size();
    send_plan();
    run_random(100, 0);
    drain();

    configure(TAG_RMC, 4'd3, 4'd5);
    calm <= 1'b1;
    run_random(90, 0);
    calm <= 1'b0;
    drain();

    // Both fields open at the saturated comma count.
    configure(24'hFFFFFF, 4'd15, 4'd15);
    run_random(90, 15);
    drain();

    // Single-byte tag right after '$', first field before the first comma.
    configure(24'h000041, 4'd0, 4'd2);
    write_reg(CFG_SPARE, 24'($urandom_range(24'hFFFFFF)));
    cfg_valid <= 1'b0;
    run_random(80, 0);
    drain();

    configure(TAG_RESET, 4'd2, 4'd2);
    run_random(80, 0);
    drain();

    repeat (10) @(posedge clk);
    $display("Checked %0d field characters and %0d field ends from %0d sentence bytes",
             chars_checked, ends_checked, sentence_bytes);
    $display("over five register settings, with and without idle cycles on both sides.");
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/gpfe_pkg.sv
rtl/gpfe_front.sv
rtl/gpfe_queue.sv
rtl/gpfe_back.sv
rtl/gll_position_field_extractor.sv
rtl/gpfe_checker.sv
verif/gpfe_field_checker.sv
verif/testbench.sv
